### sv/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types, register codes and reset values for the heater thermostat.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int ACC_BITS_DEF   = 24;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int TEMP_W    = 10;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = TEMP_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = GAIN_W;

    // register codes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_BELOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_ABOVE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT_GAIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KD_PER_DT_GAIN = 3'd6;

    // reset values
    localparam logic [TEMP_W-1:0] SETPOINT_RST    = 10'sd25;
    localparam logic [TEMP_W-1:0] UPPER_LIMIT_RST = 10'sd60;
    localparam logic [TEMP_W-1:0] ON_BELOW_RST    = 10'sd15;
    localparam logic [TEMP_W-1:0] OFF_ABOVE_RST   = 10'sd35;
    localparam logic [GAIN_W-1:0] KP_GAIN_RST     = GAIN_W'(1 << GAIN_FRAC_BITS);
    localparam logic [GAIN_W-1:0] KI_DT_GAIN_RST  = '0;
    localparam logic [GAIN_W-1:0] KD_GAIN_RST     = '0;

    typedef struct packed {
        logic [TEMP_W-1:0] setpoint;
        logic [TEMP_W-1:0] upper_limit;
        logic [TEMP_W-1:0] on_below;
        logic [TEMP_W-1:0] off_above;
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_dt_gain;
        logic [GAIN_W-1:0] kd_per_dt_gain;
    } cfg_t;

    typedef struct packed {
        logic heater_on;
        logic state_changed;
        logic over_limit;
    } res_t;

endpackage

### sv/pht_cfg_regs.sv
// ----------------------------------------------------------------------------
// pht_cfg_regs
// Configuration register file; write-only, index decoded, unused bits dropped.
// ----------------------------------------------------------------------------
module pht_cfg_regs
    import pht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint       <= SETPOINT_RST;
            cfg_reg.upper_limit    <= UPPER_LIMIT_RST;
            cfg_reg.on_below       <= ON_BELOW_RST;
            cfg_reg.off_above      <= OFF_ABOVE_RST;
            cfg_reg.kp_gain        <= KP_GAIN_RST;
            cfg_reg.ki_dt_gain     <= KI_DT_GAIN_RST;
            cfg_reg.kd_per_dt_gain <= KD_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SETPOINT:       cfg_reg.setpoint       <= cfg_data[TEMP_W-1:0];
                REG_UPPER_LIMIT:    cfg_reg.upper_limit    <= cfg_data[TEMP_W-1:0];
                REG_ON_BELOW:       cfg_reg.on_below       <= cfg_data[TEMP_W-1:0];
                REG_OFF_ABOVE:      cfg_reg.off_above      <= cfg_data[TEMP_W-1:0];
                REG_KP_GAIN:        cfg_reg.kp_gain        <= cfg_data;
                REG_KI_DT_GAIN:     cfg_reg.ki_dt_gain     <= cfg_data;
                REG_KD_PER_DT_GAIN: cfg_reg.kd_per_dt_gain <= cfg_data;
                default:            ; // unmapped index: ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/pht_step.sv
// ----------------------------------------------------------------------------
// pht_step
// One controller step: error, saturating accumulate, PID sign, heater decision.
// ----------------------------------------------------------------------------
module pht_step
    import pht_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
)
(
    input  cfg_t                cfg,
    input  logic [TEMP_W-1:0]   temp,
    input  logic                heater,
    input  logic [ACC_BITS-1:0] acc,
    input  logic [ERR_W-1:0]    last_err,
    output logic                heater_next,
    output logic [ACC_BITS-1:0] acc_next,
    output logic [ERR_W-1:0]    last_err_next,
    output res_t                res
);

    localparam int ACCX_W = ACC_BITS + 1;
    localparam int PKP_W  = GAIN_W + ERR_W;
    localparam int PKI_W  = GAIN_W + ACC_BITS;
    localparam int DIFF_W = ERR_W + 1;
    localparam int PKD_W  = GAIN_W + DIFF_W;
    localparam int SUM_W  = PKI_W + 2;
    localparam logic signed [ACCX_W-1:0] ACC_MAX = {2'b00, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACCX_W-1:0] ACC_MIN = -ACC_MAX;

    logic                     over;
    logic signed [ERR_W-1:0]  err;
    logic signed [ACCX_W-1:0] acc_sum;
    logic signed [ACC_BITS-1:0] acc_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PKP_W-1:0]  p_kp;
    logic signed [PKI_W-1:0]  p_ki;
    logic signed [PKD_W-1:0]  p_kd;
    logic signed [SUM_W-1:0]  sum;
    logic                     sum_pos;
    logic                     pid_heater;

    assign over = $signed(temp) >= $signed(cfg.upper_limit);

    assign err = $signed({cfg.setpoint[TEMP_W-1], cfg.setpoint})
               - $signed({temp[TEMP_W-1], temp});

    assign acc_sum = $signed({acc[ACC_BITS-1], acc})
                   + $signed({{(ACCX_W-ERR_W){err[ERR_W-1]}}, err});

    always_comb
    begin
        if (acc_sum > ACC_MAX)
            acc_sat = ACC_MAX[ACC_BITS-1:0];
        else if (acc_sum < ACC_MIN)
            acc_sat = ACC_MIN[ACC_BITS-1:0];
        else
            acc_sat = acc_sum[ACC_BITS-1:0];
    end

    assign diff = $signed({err[ERR_W-1], err}) - $signed({last_err[ERR_W-1], last_err});

    assign p_kp = $signed(cfg.kp_gain) * err;
    assign p_ki = $signed(cfg.ki_dt_gain) * acc_sat;
    assign p_kd = $signed(cfg.kd_per_dt_gain) * diff;

    assign sum = $signed({{(SUM_W-PKP_W){p_kp[PKP_W-1]}}, p_kp})
               + $signed({{(SUM_W-PKI_W){p_ki[PKI_W-1]}}, p_ki})
               + $signed({{(SUM_W-PKD_W){p_kd[PKD_W-1]}}, p_kd});

    assign sum_pos = !sum[SUM_W-1] && (sum != '0);

    always_comb
    begin
        if (sum_pos && ($signed(temp) < $signed(cfg.on_below)))
            pid_heater = 1'b1;
        else if (!sum_pos || ($signed(temp) > $signed(cfg.off_above)))
            pid_heater = 1'b0;
        else
            pid_heater = heater;
    end

    always_comb
    begin
        if (over)
        begin
            // forced off; controller memory cleared only on an actual turn-off
            heater_next   = 1'b0;
            acc_next      = heater ? '0 : acc;
            last_err_next = heater ? '0 : last_err;
        end
        else
        begin
            heater_next   = pid_heater;
            acc_next      = acc_sat;
            last_err_next = err;
        end
    end

    assign res.heater_on     = heater_next;
    assign res.state_changed = heater_next ^ heater;
    assign res.over_limit    = over;

endmodule

### sv/pid_heater_thermostat_core.sv
// ----------------------------------------------------------------------------
// pid_heater_thermostat_core
// PID-driven on/off heater thermostat, one result per temperature sample.
// ----------------------------------------------------------------------------
// Usage:
//   - Input channel (in_valid/in_ready/temp_sample): one signed temperature
//     sample per transaction.
//   - Output channel (out_valid/out_ready/heater_on/state_changed/over_limit):
//     exactly one result transaction per input transaction, in order.
//   - Config port (cfg_we/cfg_index/cfg_data): single-cycle writes, only
//     while the block is idle. Unmapped indexes are ignored.
//   - Path: a sample goes into the input register, then one compute pass
//     writes the result register and raises out_valid, unless a held result blocks it.
//   - Throughput: 1 transaction per cycle while out_ready stays high. The limit
//     is the state loop: accumulator, three multiplies, sum sign and heater
//     decision are combinational so the next sample sees the updated state.
//   - Reset: heater off, accumulator and previous error zero, registers at
//     their defaults, both pipeline stages empty.
//   - Stall: when out_ready is low the result is held; one more sample is
//     held in the input register, after which in_ready drops.
// ----------------------------------------------------------------------------
module pid_heater_thermostat_core
    import pht_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input samples
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TEMP_W-1:0]    temp_sample,
    // results
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 heater_on,
    output logic                 state_changed,
    output logic                 over_limit,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t cfg;

    // input stage
    logic              s1_valid_reg;
    logic [TEMP_W-1:0] s1_temp_reg;

    // controller state
    logic                heater_reg;
    logic                heater_next;
    logic [ACC_BITS-1:0] acc_reg;
    logic [ACC_BITS-1:0] acc_next;
    logic [ERR_W-1:0]    last_err_reg;
    logic [ERR_W-1:0]    last_err_next;

    // result stage
    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;

    logic advance;

    pht_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pht_step #(
        .ACC_BITS (ACC_BITS)
    ) u_step (
        .cfg           (cfg),
        .temp          (s1_temp_reg),
        .heater        (heater_reg),
        .acc           (acc_reg),
        .last_err      (last_err_reg),
        .heater_next   (heater_next),
        .acc_next      (acc_next),
        .last_err_next (last_err_next),
        .res           (res_next)
    );

    // compute pass fires when a sample waits and the result slot is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            heater_reg    <= 1'b0;
            acc_reg       <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                heater_reg    <= heater_next;
                acc_reg       <= acc_next;
                last_err_reg  <= last_err_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_temp_reg <= temp_sample;
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign heater_on     = res_reg.heater_on;
    assign state_changed = res_reg.state_changed;
    assign over_limit    = res_reg.over_limit;

endmodule

### verif/tb_pid_heater_thermostat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_heater_thermostat_core
// Self-checking bench for the PID heater thermostat. Temperature samples go in
// over a valid/ready channel while a local model of the controller predicts
// heater_on, state_changed and over_limit for every accepted sample; results
// are checked in order as they leave the block. Covers reset values, register
// extremes, integral action, input backpressure and random traffic under
// several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_pid_heater_thermostat_core;
    import pht_pkg::*;

    localparam int    ACC_W       = ACC_BITS_DEF;
    // symmetric saturation bound of the error accumulator
    localparam longint ACC_LIM    = (longint'(1) <<< (ACC_W - 1)) - 1;
    // unmapped register index, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int    HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int    STALL_LIMIT = 4000;  // cycles with no transaction at all
    localparam int    INT_LEG     = 40;    // samples per leg of the integral test

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [TEMP_W-1:0]    temp_sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 heater_on;
    logic                 state_changed;
    logic                 over_limit;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    pid_heater_thermostat_core #(.ACC_BITS(ACC_W)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .temp_sample   (temp_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .heater_on     (heater_on),
        .state_changed (state_changed),
        .over_limit    (over_limit),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Thermostat model: own copy of registers and controller state
    // ------------------------------------------------------------------
    cfg_t   cfg_model;
    logic   heater_model;
    longint err_sum_model;   // error accumulator
    longint prev_err_model;  // previous error

    res_t   heater_expect_q[$];  // predicted results, oldest first
    int     n_errors = 0;

    // idle/stall mix, percent of cycles
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_reqs      = 0;  // bumped by a test to request a long hold-off
    int     walk_temp      = 20; // random-walk temperature for random traffic

    function automatic void model_reset();
        cfg_model.setpoint       = SETPOINT_RST;
        cfg_model.upper_limit    = UPPER_LIMIT_RST;
        cfg_model.on_below       = ON_BELOW_RST;
        cfg_model.off_above      = OFF_ABOVE_RST;
        cfg_model.kp_gain        = KP_GAIN_RST;
        cfg_model.ki_dt_gain     = KI_DT_GAIN_RST;
        cfg_model.kd_per_dt_gain = KD_GAIN_RST;
        heater_model   = 1'b0;
        err_sum_model  = 0;
        prev_err_model = 0;
    endfunction

    // bits above a register's width are dropped, unmapped index ignored
    function automatic void model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        case (idx)
            REG_SETPOINT:       cfg_model.setpoint       = data[TEMP_W-1:0];
            REG_UPPER_LIMIT:    cfg_model.upper_limit    = data[TEMP_W-1:0];
            REG_ON_BELOW:       cfg_model.on_below       = data[TEMP_W-1:0];
            REG_OFF_ABOVE:      cfg_model.off_above      = data[TEMP_W-1:0];
            REG_KP_GAIN:        cfg_model.kp_gain        = data;
            REG_KI_DT_GAIN:     cfg_model.ki_dt_gain     = data;
            REG_KD_PER_DT_GAIN: cfg_model.kd_per_dt_gain = data;
            default: ;
        endcase
    endfunction

    // one controller step; updates model state and returns the result
    function automatic res_t heater_step(input logic [TEMP_W-1:0] sample);
        longint tv;
        longint err;
        longint acc;
        longint pid_sum;
        logic   nxt;
        res_t   r;
        tv = longint'($signed(sample));
        if (tv >= longint'($signed(cfg_model.upper_limit)))
        begin
            // forced off only if it was on; memory cleared with it
            r.state_changed = heater_model;
            if (heater_model)
            begin
                heater_model   = 1'b0;
                err_sum_model  = 0;
                prev_err_model = 0;
            end
            r.heater_on  = heater_model;
            r.over_limit = 1'b1;
            return r;
        end
        err = longint'($signed(cfg_model.setpoint)) - tv;
        acc = err_sum_model + err;
        if (acc > ACC_LIM)
            acc = ACC_LIM;
        if (acc < -ACC_LIM)
            acc = -ACC_LIM;
        err_sum_model = acc;
        // exact sum in Q.8; only its sign matters
        pid_sum = longint'($signed(cfg_model.kp_gain)) * err
                + longint'($signed(cfg_model.ki_dt_gain)) * acc
                + longint'($signed(cfg_model.kd_per_dt_gain)) * (err - prev_err_model);
        if (pid_sum > 0 && tv < longint'($signed(cfg_model.on_below)))
            nxt = 1'b1;
        else if (pid_sum <= 0 || tv > longint'($signed(cfg_model.off_above)))
            nxt = 1'b0;
        else
            nxt = heater_model;
        r.heater_on     = nxt;
        r.state_changed = (nxt != heater_model);
        r.over_limit    = 1'b0;
        heater_model    = nxt;
        prev_err_model  = err;
        return r;
    endfunction

    function automatic cfg_t mk_cfg(input int tgt, input int upl, input int onb,
                                    input int offa, input int kp, input int ki,
                                    input int kd);
        cfg_t c;
        c.setpoint       = tgt[TEMP_W-1:0];
        c.upper_limit    = upl[TEMP_W-1:0];
        c.on_below       = onb[TEMP_W-1:0];
        c.off_above      = offa[TEMP_W-1:0];
        c.kp_gain        = kp[GAIN_W-1:0];
        c.ki_dt_gain     = ki[GAIN_W-1:0];
        c.kd_per_dt_gain = kd[GAIN_W-1:0];
        return c;
    endfunction

    // plausible thermostat setup (ordered thresholds, modest gains) or
    // anything at all
    function automatic cfg_t random_cfg(input bit plausible);
        int tgt;
        int onb;
        int offa;
        if (!plausible)
            return mk_cfg($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
        tgt  = int'($urandom_range(200)) - 100;
        onb  = tgt - int'($urandom_range(20));
        offa = tgt + int'($urandom_range(20));
        return mk_cfg(tgt, offa + int'($urandom_range(40)), onb, offa,
                      int'($urandom_range(1024)) - 256,
                      int'($urandom_range(128)) - 64,
                      int'($urandom_range(1024)) - 512);
    endfunction

    // mostly a slow temperature drift, some samples right at a threshold,
    // some anywhere in range
    function automatic logic [TEMP_W-1:0] pick_sample();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 55)
            v = walk_temp + int'($urandom_range(8)) - 4;
        else if (pick < 80)
        begin
            case ($urandom_range(3))
                0:       v = int'($signed(cfg_model.setpoint));
                1:       v = int'($signed(cfg_model.on_below));
                2:       v = int'($signed(cfg_model.off_above));
                default: v = int'($signed(cfg_model.upper_limit));
            endcase
            v = v + int'($urandom_range(6)) - 3;
        end
        else
            v = int'($urandom_range(1023)) - 512;
        if (v > 511)
            v = 511;
        if (v < -512)
            v = -512;
        walk_temp = v;
        return v[TEMP_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // All tasks start and end on a rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        model_reg_write(idx, data);
        @(posedge clk);
    endtask

    // Block must be idle. Junk goes in the unused upper bits of the narrow
    // registers, and one write lands on the unmapped index.
    task automatic apply_config(input cfg_t c);
        logic [CFG_W-1:0] d;
        d = CFG_W'($urandom()); d[TEMP_W-1:0] = c.setpoint;    write_reg(REG_SETPOINT, d);
        d = CFG_W'($urandom()); d[TEMP_W-1:0] = c.upper_limit; write_reg(REG_UPPER_LIMIT, d);
        d = CFG_W'($urandom()); d[TEMP_W-1:0] = c.on_below;    write_reg(REG_ON_BELOW, d);
        write_reg(REG_UNMAPPED, CFG_W'($urandom()));
        d = CFG_W'($urandom()); d[TEMP_W-1:0] = c.off_above;   write_reg(REG_OFF_ABOVE, d);
        write_reg(REG_KP_GAIN, c.kp_gain);
        write_reg(REG_KI_DT_GAIN, c.ki_dt_gain);
        write_reg(REG_KD_PER_DT_GAIN, c.kd_per_dt_gain);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample, wait for the transaction, then queue its prediction.
    // in_valid is left high so back-to-back samples need no extra edge.
    task automatic send_sample(input logic [TEMP_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        temp_sample <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        heater_expect_q.push_back(heater_step(t));
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (heater_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_reqs)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (heater_expect_q.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                n_errors++;
            end
            else
            begin
                want = heater_expect_q.pop_front();
                if (heater_on !== want.heater_on)
                begin
                    $error("heater_on: expected %0b, got %0b", want.heater_on, heater_on);
                    n_errors++;
                end
                if (state_changed !== want.state_changed)
                begin
                    $error("state_changed: expected %0b, got %0b",
                           want.state_changed, state_changed);
                    n_errors++;
                end
                if (over_limit !== want.over_limit)
                begin
                    $error("over_limit: expected %0b, got %0b", want.over_limit, over_limit);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_pid_heater_thermostat_core: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers (setpoint 25, limit 60, on below 15, off above 35, P only):
    // turn on, hold in the band, turn off, over limit with heater off and on,
    // field extremes and the threshold edges.
    task automatic test_reset_values();
        int temps[$] = '{0, 10, 20, 30, 60, -512, 511, 14, 15, 16, 25, -1, 35, 36, 59, 61};
        set_idling(0, 0);
        foreach (temps[i])
            send_sample(temps[i][TEMP_W-1:0]);
        drain_results();
    endtask

    // Every register at its extremes, a few samples each.
    task automatic test_register_extremes();
        cfg_t cfgs[3];
        int   temps[4];
        cfgs[0] = mk_cfg(511, 511, 511, -512, 32767, 32767, 32767);
        cfgs[1] = mk_cfg(-512, -512, -512, 511, -32768, -32768, -32768);  // all over limit
        cfgs[2] = mk_cfg(0, 511, 511, 511, -32768, 0, 32767);
        temps   = '{-512, 510, -1, 1};
        set_idling(0, 0);
        foreach (cfgs[c])
        begin
            apply_config(cfgs[c]);
            foreach (temps[i])
                send_sample(temps[i][TEMP_W-1:0]);
            drain_results();
        end
    endtask

    // Pure integral control with thresholds out of the way: the heater
    // follows the sign of the accumulator. Drive it up with the largest
    // error, down through zero, then back up through zero.
    task automatic test_integral_action();
        set_idling(0, 0);
        apply_config(mk_cfg(511, 511, 511, 511, 0, 1, 0));
        repeat (INT_LEG) send_sample(10'sh200);            // error +1023
        drain_results();
        apply_config(mk_cfg(-512, 511, 511, 511, 0, 1, 0));
        repeat (INT_LEG + 5) send_sample(10'sd510);        // error -1022
        drain_results();
        apply_config(mk_cfg(511, 511, 511, 511, 0, 1, 0));
        repeat (10) send_sample(10'sh200);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so
    // both stages fill and in_ready must drop.
    task automatic test_input_backpressure();
        set_idling(0, 0);
        apply_config(random_cfg(1'b1));
        hold_reqs++;
        repeat (40) send_sample(pick_sample());
        drain_results();
    endtask

    // Random traffic in three idle mixes, new settings every 90 samples.
    task automatic test_random_traffic();
        int send_pcts[3];
        int recv_pcts[3];
        send_pcts = '{32, 70, 0};
        recv_pcts = '{70, 32, 0};
        for (int ph = 0; ph < 3; ph++)
        begin
            set_idling(send_pcts[ph], recv_pcts[ph]);
            for (int blk = 0; blk < 4; blk++)
            begin
                // one fully random setting per phase, the rest plausible
                apply_config(random_cfg(blk != 2));
                repeat (90) send_sample(pick_sample());
                drain_results();
            end
        end
    endtask

    initial
    begin
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_extremes();
        test_integral_action();
        test_input_backpressure();
        test_random_traffic();

        if (n_errors == 0)
            $display("tb_pid_heater_thermostat_core: done, clean");
        else
            $display("tb_pid_heater_thermostat_core: done, errors");
        $finish;
    end

endmodule

### files.f
sv/pht_pkg.sv
sv/pht_cfg_regs.sv
sv/pht_step.sv
sv/pid_heater_thermostat_core.sv
verif/tb_pid_heater_thermostat_core.sv
